### hdl/mcr_pkg.sv
// Shared types, protocol byte codes and the microcode control store of the card responder.
package mcr_pkg;

	// Card geometry
	localparam int unsigned SECTOR_SIZE  = 128;
	localparam int unsigned SECTOR_COUNT = 1024;
	localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_SIZE);
	localparam int unsigned MEM_AW       = 17;
	localparam int unsigned MEM_DEPTH    = 1 << MEM_AW;
	localparam int unsigned IDENT_LEN    = 4;
	localparam int unsigned SECTOR_W     = 10;

	// Host command bytes
	localparam logic [7:0] CMD_FRAME   = 8'h81;
	localparam logic [7:0] CMD_READ    = 8'h52;
	localparam logic [7:0] CMD_WRITE   = 8'h57;
	localparam logic [7:0] CMD_IDENT   = 8'h53;
	localparam logic [7:0] CMD_PING    = 8'h20;
	localparam logic [7:0] CMD_GAME_ID = 8'h21;

	// Card reply bytes
	localparam logic [7:0] REPLY_ID1   = 8'h5A;
	localparam logic [7:0] REPLY_ID2   = 8'h5D;
	localparam logic [7:0] REPLY_ACK1  = 8'h5C;
	localparam logic [7:0] REPLY_ACK2  = 8'h5D;
	localparam logic [7:0] REPLY_GOOD  = 8'h47;
	localparam logic [7:0] REPLY_BAD   = 8'h4E;
	localparam logic [7:0] REPLY_ABORT = 8'hFF;
	localparam logic [7:0] REPLY_PING  = 8'h27;
	localparam logic [7:0] REPLY_FILL  = 8'h00;

	localparam logic [7:0] FLAG_RESET      = 8'h08;
	localparam logic [7:0] FLAG_CLEAR_MASK = 8'hF7;
	localparam logic [SECTOR_W-1:0] TEST_SECTOR_RESET = 10'd63;

	// Microprogram steps, one per exchange phase
	typedef enum logic [4:0] {
		ST_IDLE, ST_CMD, ST_HDR1, ST_HDR2, ST_ADDR_MSB, ST_ADDR_LSB,
		ST_R_ACK2, ST_R_MSB, ST_R_LSB, ST_R_DATA, ST_R_CHK, ST_R_GOOD,
		ST_W_DATA, ST_W_CHK, ST_W_ACK2, ST_W_STATUS,
		ST_ID_ACK1, ST_ID_ACK2, ST_ID_DATA, ST_PING1, ST_PING2,
		ST_GID_LEN, ST_GID_DATA, ST_DONE
	} step_t;

	typedef enum logic [1:0] {
		K_NONE, K_READ, K_WRITE, K_ID
	} kind_t;

	// Reply byte sources
	typedef enum logic [3:0] {
		REP_CONST, REP_FLAG, REP_HOST, REP_MEM, REP_CHK, REP_SEC_MSB,
		REP_SEC_LSB, REP_IDENT, REP_STATUS, REP_CMD, REP_LSB
	} rep_sel_t;

	// Branch conditions
	typedef enum logic [3:0] {
		C_TRUE, C_FRAME81, C_CMD_KNOWN, C_LSB_OK, C_IS_ID, C_SEC_VALID,
		C_LAST_SECTOR, C_LAST_IDENT, C_LEN_NZ, C_GID_LAST
	} cond_t;

	// Next-step modes
	typedef enum logic [1:0] {
		J_SEQ, J_COND, J_CMD, J_LSB
	} jmode_t;

	// Reply when the condition fails
	typedef enum logic [1:0] {
		FR_KEEP, FR_ABORT, FR_RELEASE
	} fail_t;

	typedef struct packed {
		logic kind_load;
		logic prev_load;
		logic addr_load;
		logic idx_clear;
		logic idx_inc;
		logic idx_dec;
		logic idx_host;
		logic chk_mem;
		logic chk_host;
		logic mem_write;
		logic status;
	} ops_t;

	typedef struct packed {
		rep_sel_t   rep_sel;
		logic [7:0] rep_const;
		logic       drive;
		cond_t      cond;
		jmode_t     jmode;
		step_t      step_a;
		step_t      step_b;
		fail_t      fail;
		ops_t       ops;
	} ctrl_t;

	// Sequencer to datapath
	typedef struct packed {
		ctrl_t ctrl;
		logic  ok;
	} seq_out_t;

	// Datapath status used by branch conditions
	typedef struct packed {
		logic is_read;
		logic is_id;
		logic sec_valid;
		logic lsb_valid;
		logic last_sector;
		logic last_ident;
		logic gid_last;
	} dp_stat_t;

	function automatic logic [7:0] ident_byte(input logic [1:0] i);
		case (i)
			2'd0: ident_byte = 8'h04;
			2'd1: ident_byte = 8'h00;
			2'd2: ident_byte = 8'h00;
			default: ident_byte = 8'h80;
		endcase
	endfunction

	function automatic kind_t cmd_kind(input logic [7:0] h);
		case (h)
			CMD_READ:  cmd_kind = K_READ;
			CMD_WRITE: cmd_kind = K_WRITE;
			CMD_IDENT: cmd_kind = K_ID;
			default:   cmd_kind = K_NONE;
		endcase
	endfunction

	// Control store: one control word per step
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '0;
		w.rep_sel = REP_CONST;
		w.rep_const = REPLY_FILL;
		w.drive = 1'b1;
		w.cond = C_TRUE;
		w.jmode = J_SEQ;
		w.step_a = ST_DONE;
		w.step_b = ST_DONE;
		w.fail = FR_KEEP;
		case (s)
			ST_IDLE: begin
				w.rep_sel = REP_FLAG;
				w.cond = C_FRAME81;
				w.jmode = J_COND;
				w.step_a = ST_CMD;
				w.step_b = ST_IDLE;
				w.fail = FR_RELEASE;
			end
			ST_CMD: begin
				w.rep_sel = REP_CMD;
				w.cond = C_CMD_KNOWN;
				w.jmode = J_CMD;
				w.step_b = ST_IDLE;
				w.fail = FR_RELEASE;
				w.ops.kind_load = 1'b1;
			end
			ST_HDR1: begin
				w.rep_const = REPLY_ID2;
				w.cond = C_IS_ID;
				w.jmode = J_COND;
				w.step_a = ST_ID_ACK1;
				w.step_b = ST_HDR2;
			end
			ST_HDR2: begin
				w.step_a = ST_ADDR_MSB;
			end
			ST_ADDR_MSB: begin
				w.rep_sel = REP_HOST;
				w.step_a = ST_ADDR_LSB;
				w.ops.prev_load = 1'b1;
			end
			ST_ADDR_LSB: begin
				w.rep_sel = REP_LSB;
				w.cond = C_LSB_OK;
				w.jmode = J_LSB;
				w.step_b = ST_DONE;
				w.fail = FR_ABORT;
				w.ops.addr_load = 1'b1;
			end
			ST_R_ACK2: begin
				w.rep_const = REPLY_ACK2;
				w.step_a = ST_R_MSB;
			end
			ST_R_MSB: begin
				w.rep_sel = REP_SEC_MSB;
				w.cond = C_SEC_VALID;
				w.jmode = J_COND;
				w.step_a = ST_R_LSB;
				w.step_b = ST_DONE;
				w.fail = FR_ABORT;
			end
			ST_R_LSB: begin
				w.rep_sel = REP_SEC_LSB;
				w.step_a = ST_R_DATA;
				w.ops.idx_clear = 1'b1;
			end
			ST_R_DATA: begin
				w.rep_sel = REP_MEM;
				w.cond = C_LAST_SECTOR;
				w.jmode = J_COND;
				w.step_a = ST_R_CHK;
				w.step_b = ST_R_DATA;
				w.ops.chk_mem = 1'b1;
				w.ops.idx_inc = 1'b1;
			end
			ST_R_CHK: begin
				w.rep_sel = REP_CHK;
				w.step_a = ST_R_GOOD;
			end
			ST_R_GOOD: begin
				w.rep_const = REPLY_GOOD;
				w.step_a = ST_DONE;
			end
			ST_W_DATA: begin
				w.rep_sel = REP_HOST;
				w.cond = C_LAST_SECTOR;
				w.jmode = J_COND;
				w.step_a = ST_W_CHK;
				w.step_b = ST_W_DATA;
				w.ops.mem_write = 1'b1;
				w.ops.chk_host = 1'b1;
				w.ops.idx_inc = 1'b1;
			end
			ST_W_CHK: begin
				w.rep_const = REPLY_ACK1;
				w.step_a = ST_W_ACK2;
				w.ops.prev_load = 1'b1;
			end
			ST_W_ACK2: begin
				w.rep_const = REPLY_ACK2;
				w.step_a = ST_W_STATUS;
			end
			ST_W_STATUS: begin
				w.rep_sel = REP_STATUS;
				w.step_a = ST_DONE;
				w.ops.status = 1'b1;
			end
			ST_ID_ACK1: begin
				w.rep_const = REPLY_ACK1;
				w.step_a = ST_ID_ACK2;
			end
			ST_ID_ACK2: begin
				w.rep_const = REPLY_ACK2;
				w.step_a = ST_ID_DATA;
				w.ops.idx_clear = 1'b1;
			end
			ST_ID_DATA: begin
				w.rep_sel = REP_IDENT;
				w.cond = C_LAST_IDENT;
				w.jmode = J_COND;
				w.step_a = ST_DONE;
				w.step_b = ST_ID_DATA;
				w.ops.idx_inc = 1'b1;
			end
			ST_PING1: begin
				w.step_a = ST_PING2;
			end
			ST_PING2: begin
				w.rep_const = REPLY_PING;
				w.step_a = ST_DONE;
			end
			ST_GID_LEN: begin
				w.cond = C_LEN_NZ;
				w.jmode = J_COND;
				w.step_a = ST_GID_DATA;
				w.step_b = ST_DONE;
				w.ops.idx_host = 1'b1;
			end
			ST_GID_DATA: begin
				w.rep_sel = REP_HOST;
				w.cond = C_GID_LAST;
				w.jmode = J_COND;
				w.step_a = ST_DONE;
				w.step_b = ST_GID_DATA;
				w.ops.idx_dec = 1'b1;
			end
			default: begin
				// transaction over: release until the next frame
				w.drive = 1'b0;
				w.step_a = ST_IDLE;
			end
		endcase
		ucode = w;
	endfunction

endpackage

### hdl/memory_card_command_responder.sv
// Top level of the card responder: beat capture, fetch and execute cycles, result register.
// An accepted beat is fetched (valid_s1), then executed (valid_s2), then shown under done.
// busy is high for the fetch cycle that reads the image; no new beat is taken until it falls.
// The result register shows each beat for one cycle under done; the receiver cannot stall it.
// Reset (arst_n low, asynchronous): step counter to idle, flag byte 0x08, test sector 63,
// transaction registers zero; the card image holds nothing defined until preloaded.
module memory_card_command_responder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic                          frame_start,
	input  logic [7:0]                    host_byte,
	input  logic [mcr_pkg::MEM_AW-1:0]    load_address,
	input  logic                          test_sector_we,
	input  logic [mcr_pkg::SECTOR_W-1:0]  test_sector_wdata,
	output logic                          done,
	output logic [7:0]                    reply_byte,
	output logic                          reply_drive,
	output logic                          sync_valid,
	output logic [mcr_pkg::SECTOR_W-1:0]  sync_sector
);

	logic                       valid_s1;
	logic                       valid_s2;
	logic                       cmd_q;
	logic                       frame_start_q;
	logic [7:0]                 host_byte_q;
	logic [mcr_pkg::MEM_AW-1:0] load_address_q;
	logic                       done_q;
	logic [7:0]                 reply_byte_q;
	logic                       reply_drive_q;
	logic                       sync_valid_q;
	logic [mcr_pkg::SECTOR_W-1:0] sync_sector_q;

	mcr_pkg::seq_out_t seq;
	mcr_pkg::dp_stat_t stat;
	logic [7:0]                 dp_reply_byte;
	logic                       dp_reply_drive;
	logic                       dp_sync_valid;
	logic [mcr_pkg::SECTOR_W-1:0] dp_sync_sector;
	logic                       accept;

	assign accept = start && !busy;
	assign busy = valid_s1;

	// Advance the beat through fetch and execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			done_q <= valid_s2;
		end
	end

	// Hold the accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			frame_start_q <= frame_start;
			host_byte_q <= host_byte;
			load_address_q <= load_address;
		end
	end

	// Register the result of the execute cycle
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			reply_byte_q <= dp_reply_byte;
			reply_drive_q <= dp_reply_drive;
			sync_valid_q <= dp_sync_valid;
			sync_sector_q <= dp_sync_sector;
		end
	end

	mcr_sequencer u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (valid_s2 && !cmd_q),
		.frame_start (frame_start_q),
		.host_byte   (host_byte_q),
		.stat        (stat),
		.seq         (seq)
	);

	mcr_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.mem_en            (valid_s1),
		.exec              (valid_s2),
		.cmd               (cmd_q),
		.host_byte         (host_byte_q),
		.load_address      (load_address_q),
		.test_sector_we    (test_sector_we),
		.test_sector_wdata (test_sector_wdata),
		.seq               (seq),
		.stat              (stat),
		.reply_byte        (dp_reply_byte),
		.reply_drive       (dp_reply_drive),
		.sync_valid        (dp_sync_valid),
		.sync_sector       (dp_sync_sector)
	);

	assign done = done_q;
	assign reply_byte = reply_byte_q;
	assign reply_drive = reply_drive_q;
	assign sync_valid = sync_valid_q;
	assign sync_sector = sync_sector_q;

`ifndef SYNTH
	// Fetch and execute never overlap
	a_stage_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !valid_s1)
		else $error("fetch and execute cycles overlap");

	// Every accepted beat gives one result strobe on done
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result strobe missing after accepted beat");

	// A released line carries a zero byte
	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !reply_drive |-> reply_byte == 8'd0)
		else $error("reply byte nonzero on released line");

	// No sync request means no sector
	a_sync_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !sync_valid |-> sync_sector == '0)
		else $error("sync sector nonzero without sync request");
`endif

endmodule

### hdl/mcr_sequencer.sv
// Microcode sequencer: step counter, control store lookup, branch conditions and dispatch.
module mcr_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               frame_start,
	input  logic [7:0]         host_byte,
	input  mcr_pkg::dp_stat_t  stat,
	output mcr_pkg::seq_out_t  seq
);

	mcr_pkg::step_t step_q;
	mcr_pkg::step_t step;
	mcr_pkg::step_t step_nxt;
	mcr_pkg::step_t cmd_target;
	mcr_pkg::ctrl_t ctrl;
	logic           cmd_known;
	logic           ok;

	// Restart the frame on a frame start beat
	assign step = frame_start ? mcr_pkg::ST_IDLE : step_q;
	assign ctrl = mcr_pkg::ucode(step);

	// Decode the command byte into its first step
	always_comb begin
		cmd_known = 1'b1;
		case (host_byte)
			mcr_pkg::CMD_READ, mcr_pkg::CMD_WRITE, mcr_pkg::CMD_IDENT:
				cmd_target = mcr_pkg::ST_HDR1;
			mcr_pkg::CMD_PING:
				cmd_target = mcr_pkg::ST_PING1;
			mcr_pkg::CMD_GAME_ID:
				cmd_target = mcr_pkg::ST_GID_LEN;
			default: begin
				cmd_target = mcr_pkg::ST_IDLE;
				cmd_known = 1'b0;
			end
		endcase
	end

	// Evaluate the branch condition of this step
	always_comb begin
		case (ctrl.cond)
			mcr_pkg::C_TRUE:        ok = 1'b1;
			mcr_pkg::C_FRAME81:     ok = frame_start && (host_byte == mcr_pkg::CMD_FRAME);
			mcr_pkg::C_CMD_KNOWN:   ok = cmd_known;
			mcr_pkg::C_LSB_OK:      ok = stat.is_read || stat.lsb_valid;
			mcr_pkg::C_IS_ID:       ok = stat.is_id;
			mcr_pkg::C_SEC_VALID:   ok = stat.sec_valid;
			mcr_pkg::C_LAST_SECTOR: ok = stat.last_sector;
			mcr_pkg::C_LAST_IDENT:  ok = stat.last_ident;
			mcr_pkg::C_LEN_NZ:      ok = (host_byte != 8'd0);
			mcr_pkg::C_GID_LAST:    ok = stat.gid_last;
			default:                ok = 1'b0;
		endcase
	end

	// Pick the next step
	always_comb begin
		case (ctrl.jmode)
			mcr_pkg::J_SEQ:  step_nxt = ctrl.step_a;
			mcr_pkg::J_COND: step_nxt = ok ? ctrl.step_a : ctrl.step_b;
			mcr_pkg::J_CMD:  step_nxt = ok ? cmd_target : ctrl.step_b;
			mcr_pkg::J_LSB:  step_nxt = !ok ? ctrl.step_b :
				(stat.is_read ? mcr_pkg::ST_R_ACK2 : mcr_pkg::ST_W_DATA);
			default:         step_nxt = mcr_pkg::ST_IDLE;
		endcase
	end

	// Advance the step counter once per executed exchange beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mcr_pkg::ST_IDLE;
		end else if (adv) begin
			step_q <= step_nxt;
		end
	end

	assign seq.ctrl = ctrl;
	assign seq.ok = ok;

endmodule

### hdl/mcr_datapath.sv
// Datapath: card image memory, transaction registers, checksum, reply and sync selection.
module mcr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mem_en,
	input  logic                          exec,
	input  logic                          cmd,
	input  logic [7:0]                    host_byte,
	input  logic [mcr_pkg::MEM_AW-1:0]    load_address,
	input  logic                          test_sector_we,
	input  logic [mcr_pkg::SECTOR_W-1:0]  test_sector_wdata,
	input  mcr_pkg::seq_out_t             seq,
	output mcr_pkg::dp_stat_t             stat,
	output logic [7:0]                    reply_byte,
	output logic                          reply_drive,
	output logic                          sync_valid,
	output logic [mcr_pkg::SECTOR_W-1:0]  sync_sector
);

	logic [7:0] mem [mcr_pkg::MEM_DEPTH];
	logic [7:0] rd_data_s2;

	mcr_pkg::kind_t             kind_q;
	logic [15:0]                sector_q;
	logic [7:0]                 chk_q;
	logic [7:0]                 idx_q;
	logic [7:0]                 prev_q;
	logic [7:0]                 flag_q;
	logic [mcr_pkg::SECTOR_W-1:0] test_sector_q;

	logic [mcr_pkg::MEM_AW-1:0] mem_addr;
	logic [mcr_pkg::MEM_AW-1:0] wr_addr;
	logic                       wr_en;
	logic [15:0]                new_sector;
	logic [7:0]                 src;
	logic                       sync_hit;
	mcr_pkg::ctrl_t             ctrl;

	assign ctrl = seq.ctrl;
	assign new_sector = {prev_q, host_byte};

	// Sector byte address
	assign mem_addr = (mcr_pkg::MEM_AW)'((32'(sector_q) << mcr_pkg::SECTOR_SHIFT) + 32'(idx_q));
	assign wr_addr = cmd ? load_address : mem_addr;
	assign wr_en = mem_en && (cmd || ctrl.ops.mem_write);

	// Card image: written and read in the fetch cycle, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= host_byte;
		end
		if (mem_en) begin
			rd_data_s2 <= mem[mem_addr];
		end
	end

	// Status for branch conditions
	assign stat.is_read = (kind_q == mcr_pkg::K_READ);
	assign stat.is_id = (kind_q == mcr_pkg::K_ID);
	assign stat.sec_valid = sector_q < 16'(mcr_pkg::SECTOR_COUNT);
	assign stat.lsb_valid = new_sector < 16'(mcr_pkg::SECTOR_COUNT);
	assign stat.last_sector = idx_q >= 8'(mcr_pkg::SECTOR_SIZE - 1);
	assign stat.last_ident = idx_q >= 8'(mcr_pkg::IDENT_LEN - 1);
	assign stat.gid_last = (idx_q == 8'd1);

	// Select the reply source
	always_comb begin
		case (ctrl.rep_sel)
			mcr_pkg::REP_CONST:   src = ctrl.rep_const;
			mcr_pkg::REP_FLAG:    src = flag_q;
			mcr_pkg::REP_HOST:    src = host_byte;
			mcr_pkg::REP_MEM:     src = rd_data_s2;
			mcr_pkg::REP_CHK:     src = chk_q;
			mcr_pkg::REP_SEC_MSB: src = sector_q[15:8];
			mcr_pkg::REP_SEC_LSB: src = sector_q[7:0];
			mcr_pkg::REP_IDENT:   src = mcr_pkg::ident_byte(idx_q[1:0]);
			mcr_pkg::REP_STATUS:
				src = (chk_q == prev_q) ? mcr_pkg::REPLY_GOOD : mcr_pkg::REPLY_BAD;
			mcr_pkg::REP_CMD:
				src = (mcr_pkg::cmd_kind(host_byte) != mcr_pkg::K_NONE) ?
					mcr_pkg::REPLY_ID1 : mcr_pkg::REPLY_FILL;
			mcr_pkg::REP_LSB:
				src = stat.is_read ? mcr_pkg::REPLY_ACK1 : host_byte;
			default:              src = mcr_pkg::REPLY_FILL;
		endcase
	end

	// Drive, abort or release; a preload beat answers all zeros
	always_comb begin
		reply_drive = 1'b0;
		reply_byte = 8'd0;
		if (!cmd && ctrl.drive) begin
			if (!seq.ok && ctrl.fail == mcr_pkg::FR_RELEASE) begin
				reply_drive = 1'b0;
			end else if (!seq.ok && ctrl.fail == mcr_pkg::FR_ABORT) begin
				reply_drive = 1'b1;
				reply_byte = mcr_pkg::REPLY_ABORT;
			end else begin
				reply_drive = 1'b1;
				reply_byte = src;
			end
		end
	end

	// Request sync for a finished write to any sector but the test sector
	assign sync_hit = !cmd && ctrl.ops.status &&
		(sector_q != {{(16 - mcr_pkg::SECTOR_W){1'b0}}, test_sector_q});
	assign sync_valid = sync_hit;
	assign sync_sector = sync_hit ? sector_q[mcr_pkg::SECTOR_W-1:0] : '0;

	// Hold the test sector register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_sector_q <= mcr_pkg::TEST_SECTOR_RESET;
		end else if (test_sector_we) begin
			test_sector_q <= test_sector_wdata;
		end
	end

	// Update transaction state in the execute cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= mcr_pkg::K_NONE;
			sector_q <= '0;
			chk_q <= '0;
			idx_q <= '0;
			prev_q <= '0;
			flag_q <= mcr_pkg::FLAG_RESET;
		end else if (exec && !cmd) begin
			if (ctrl.ops.kind_load) begin
				kind_q <= mcr_pkg::cmd_kind(host_byte);
			end
			if (ctrl.ops.prev_load) begin
				prev_q <= host_byte;
			end
			if (ctrl.ops.addr_load) begin
				sector_q <= new_sector;
				chk_q <= prev_q ^ host_byte;
				idx_q <= '0;
			end
			if (ctrl.ops.idx_clear) begin
				idx_q <= '0;
			end
			if (ctrl.ops.idx_inc) begin
				idx_q <= idx_q + 8'd1;
			end
			if (ctrl.ops.idx_dec) begin
				idx_q <= idx_q - 8'd1;
			end
			if (ctrl.ops.idx_host) begin
				idx_q <= host_byte;
			end
			if (ctrl.ops.chk_mem) begin
				chk_q <= chk_q ^ rd_data_s2;
			end
			if (ctrl.ops.chk_host) begin
				chk_q <= chk_q ^ host_byte;
			end
			if (ctrl.ops.status) begin
				flag_q <= flag_q & mcr_pkg::FLAG_CLEAR_MASK;
			end
		end
	end

endmodule

### verif/memory_card_command_responder_test.sv
// Self-checking bench for the memory card responder: a directed table, then random card frames.
module memory_card_command_responder_test;
	import mcr_pkg::*;

	// One reply beat as it leaves the block
	typedef struct packed {
		logic [7:0]          reply_byte;
		logic                reply_drive;
		logic                sync_valid;
		logic [SECTOR_W-1:0] sync_sector;
	} card_reply_t;

	// One row of the directed table; typed rows carry their reply, the rest use the model
	typedef struct {
		bit                is_load;
		bit                fs;
		logic [7:0]        host;
		logic [MEM_AW-1:0] addr;
		bit                typed;
		card_reply_t       want;
	} stim_row_t;

	localparam card_reply_t LINE_RELEASED = '0;
	// Identify payload, first byte in the low lane
	localparam logic [31:0] CARD_IDENT = {8'h80, 8'h00, 8'h00, 8'h04};
	localparam int DIRECTED_ROWS = 25;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                cmd;
	logic                frame_start;
	logic [7:0]          host_byte;
	logic [MEM_AW-1:0]   load_address;
	logic                test_sector_we;
	logic [SECTOR_W-1:0] test_sector_wdata;
	logic                done;
	logic [7:0]          reply_byte;
	logic                reply_drive;
	logic                sync_valid;
	logic [SECTOR_W-1:0] sync_sector;

	// Card model state
	logic [7:0]          card_image [0:MEM_DEPTH-1];
	bit                  image_known [0:MEM_DEPTH-1];
	step_t               card_step;
	kind_t               card_kind;
	logic [15:0]         card_sector;
	logic [7:0]          card_chk;
	logic [7:0]          card_idx;
	logic [7:0]          card_prev;
	logic [7:0]          card_flag;
	logic [SECTOR_W-1:0] no_sync_sector;

	card_reply_t         pending_replies [$];
	logic [7:0]          frame_q [$];
	logic [15:0]         filled_sectors [$];
	stim_row_t           directed_rows [DIRECTED_ROWS];
	bit                  idle_on;
	int                  items_sent;
	int                  fail_count;

	memory_card_command_responder DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.cmd               (cmd),
		.frame_start       (frame_start),
		.host_byte         (host_byte),
		.load_address      (load_address),
		.test_sector_we    (test_sector_we),
		.test_sector_wdata (test_sector_wdata),
		.done              (done),
		.reply_byte        (reply_byte),
		.reply_drive       (reply_drive),
		.sync_valid        (sync_valid),
		.sync_sector       (sync_sector)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	function automatic card_reply_t driven(input logic [7:0] b);
		driven = '0;
		driven.reply_byte = b;
		driven.reply_drive = 1'b1;
	endfunction

	// Card byte the current sector transfer points at
	function automatic logic [MEM_AW-1:0] image_addr();
		int unsigned lin;
		lin = card_sector * SECTOR_SIZE + card_idx;
		image_addr = lin[MEM_AW-1:0];
	endfunction

	// Advance the card model by one beat and return the reply it owes
	task automatic card_respond(input bit is_load, input bit fs, input logic [7:0] h,
			input logic [MEM_AW-1:0] la, output card_reply_t r);
		logic [7:0] rep;
		logic       drv;
		logic       sec_ok;
		logic [MEM_AW-1:0] ma;
		r = '0;
		rep = REPLY_FILL;
		drv = 1'b1;
		ma = image_addr();
		if (is_load) begin
			card_image[la] = h;
			image_known[la] = 1'b1;
		end else begin
			if (fs)
				card_step = ST_IDLE;
			sec_ok = (card_sector < SECTOR_COUNT);
			case (card_step)
				ST_IDLE: begin
					if (fs && h == CMD_FRAME) begin
						rep = card_flag;
						card_step = ST_CMD;
					end else begin
						drv = 1'b0;
					end
				end
				ST_CMD: begin
					if (h == CMD_READ || h == CMD_WRITE || h == CMD_IDENT) begin
						card_kind = (h == CMD_READ) ? K_READ : (h == CMD_WRITE) ? K_WRITE : K_ID;
						rep = REPLY_ID1;
						card_step = ST_HDR1;
					end else if (h == CMD_PING) begin
						card_kind = K_NONE;
						card_step = ST_PING1;
					end else if (h == CMD_GAME_ID) begin
						card_kind = K_NONE;
						card_step = ST_GID_LEN;
					end else begin
						card_kind = K_NONE;
						drv = 1'b0;
						card_step = ST_IDLE;
					end
				end
				ST_HDR1: begin
					rep = REPLY_ID2;
					card_step = (card_kind == K_ID) ? ST_ID_ACK1 : ST_HDR2;
				end
				ST_HDR2: card_step = ST_ADDR_MSB;
				ST_ADDR_MSB: begin
					card_prev = h;
					rep = h;
					card_step = ST_ADDR_LSB;
				end
				ST_ADDR_LSB: begin
					card_sector = {card_prev, h};
					card_chk = card_prev ^ h;
					card_idx = '0;
					if (card_kind == K_READ) begin
						rep = REPLY_ACK1;
						card_step = ST_R_ACK2;
					end else if (card_sector < SECTOR_COUNT) begin
						rep = h;
						card_step = ST_W_DATA;
					end else begin
						rep = REPLY_ABORT;
						card_step = ST_DONE;
					end
				end
				ST_R_ACK2: begin
					rep = REPLY_ACK2;
					card_step = ST_R_MSB;
				end
				ST_R_MSB: begin
					if (sec_ok) begin
						rep = card_sector[15:8];
						card_step = ST_R_LSB;
					end else begin
						rep = REPLY_ABORT;
						card_step = ST_DONE;
					end
				end
				ST_R_LSB: begin
					rep = card_sector[7:0];
					card_idx = '0;
					card_step = ST_R_DATA;
				end
				ST_R_DATA: begin
					rep = card_image[ma];
					card_chk ^= rep;
					card_idx++;
					if (card_idx >= SECTOR_SIZE)
						card_step = ST_R_CHK;
				end
				ST_R_CHK: begin
					rep = card_chk;
					card_step = ST_R_GOOD;
				end
				ST_R_GOOD: begin
					rep = REPLY_GOOD;
					card_step = ST_DONE;
				end
				ST_W_DATA: begin
					card_image[ma] = h;
					image_known[ma] = 1'b1;
					card_chk ^= h;
					rep = h;
					card_idx++;
					if (card_idx >= SECTOR_SIZE)
						card_step = ST_W_CHK;
				end
				ST_W_CHK: begin
					card_prev = h;
					rep = REPLY_ACK1;
					card_step = ST_W_ACK2;
				end
				ST_W_ACK2: begin
					rep = REPLY_ACK2;
					card_step = ST_W_STATUS;
				end
				ST_W_STATUS: begin
					// a finished write always clears the fresh-card flag
					card_flag &= FLAG_CLEAR_MASK;
					if (card_sector != no_sync_sector) begin
						r.sync_valid = 1'b1;
						r.sync_sector = card_sector[SECTOR_W-1:0];
					end
					rep = (card_chk == card_prev) ? REPLY_GOOD : REPLY_BAD;
					card_step = ST_DONE;
				end
				ST_ID_ACK1: begin
					rep = REPLY_ACK1;
					card_step = ST_ID_ACK2;
				end
				ST_ID_ACK2: begin
					rep = REPLY_ACK2;
					card_idx = '0;
					card_step = ST_ID_DATA;
				end
				ST_ID_DATA: begin
					rep = CARD_IDENT[card_idx[1:0]*8 +: 8];
					card_idx++;
					if (card_idx >= IDENT_LEN)
						card_step = ST_DONE;
				end
				ST_PING1: card_step = ST_PING2;
				ST_PING2: begin
					rep = REPLY_PING;
					card_step = ST_DONE;
				end
				ST_GID_LEN: begin
					card_idx = h;
					card_step = (h != 8'd0) ? ST_GID_DATA : ST_DONE;
				end
				ST_GID_DATA: begin
					rep = h;
					card_idx = card_idx - 8'd1;
					if (card_idx == 8'd0)
						card_step = ST_DONE;
				end
				default: begin
					drv = 1'b0;
					card_step = ST_IDLE;
				end
			endcase
			r.reply_byte = drv ? rep : 8'd0;
			r.reply_drive = drv;
		end
	endtask

	// Offer one beat, hold it until accepted, then log what the card owes for it
	task automatic send_beat(input bit is_load, input bit fs, input logic [7:0] h,
			input logic [MEM_AW-1:0] la, input bit typed, input card_reply_t want);
		int          gap;
		card_reply_t got;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		// restart the frame rather than read a card byte that holds nothing defined
		if (!is_load && !fs && card_step == ST_R_DATA && !image_known[image_addr()])
			fs = 1'b1;
		cmd = is_load;
		frame_start = fs;
		host_byte = h;
		load_address = la;
		start = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		card_respond(is_load, fs, h, la, got);
		pending_replies.push_back(typed ? want : got);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic bus_beat(input bit fs, input logic [7:0] h);
		send_beat(1'b0, fs, h, MEM_AW'($urandom_range(0, MEM_DEPTH - 1)), 1'b0, '0);
	endtask

	// Hold off new beats until every owed reply is out
	task automatic drain();
		start = 1'b0;
		do @(negedge clk); while (pending_replies.size() != 0);
	endtask

	task automatic set_test_sector(input logic [SECTOR_W-1:0] v);
		drain();
		repeat (4) @(negedge clk);
		test_sector_we = 1'b1;
		test_sector_wdata = v;
		@(negedge clk);
		test_sector_we = 1'b0;
		no_sync_sector = v;
	endtask

	// Send the built frame, sometimes cut short, sometimes with stray bytes after it
	task automatic play_frame();
		int n;
		int tail;
		n = frame_q.size();
		tail = $urandom_range(0, 2);
		if (n > 1 && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, n - 1);
			tail = 0;
		end
		for (int i = 0; i < n; i++)
			bus_beat(i == 0, frame_q[i]);
		repeat (tail) bus_beat(1'b0, 8'($urandom));
	endtask

	function automatic logic [15:0] pick_sector();
		case ($urandom_range(0, 7))
			0: pick_sector = {6'b0, no_sync_sector};
			1: pick_sector = 16'd0;
			2: pick_sector = 16'(SECTOR_COUNT - 1);
			3: pick_sector = 16'($urandom_range(SECTOR_COUNT, 16'hFFFF));
			default: pick_sector = 16'($urandom_range(0, SECTOR_COUNT - 1));
		endcase
	endfunction

	function automatic logic [7:0] any_code();
		case ($urandom_range(0, 6))
			0: any_code = CMD_FRAME;
			1: any_code = CMD_READ;
			2: any_code = CMD_WRITE;
			3: any_code = CMD_IDENT;
			4: any_code = CMD_PING;
			5: any_code = CMD_GAME_ID;
			default: any_code = 8'($urandom);
		endcase
	endfunction

	task automatic read_frame();
		logic [15:0] sec;
		if (filled_sectors.size() != 0 && $urandom_range(0, 5) != 0)
			sec = filled_sectors[$urandom_range(0, filled_sectors.size() - 1)];
		else
			sec = 16'($urandom_range(SECTOR_COUNT, 16'hFFFF));
		frame_q = {CMD_FRAME, CMD_READ, 8'($urandom), 8'($urandom), sec[15:8], sec[7:0]};
		// ack, address echo, data, checksum and status beats
		repeat (SECTOR_SIZE + 5) frame_q.push_back(8'($urandom));
		play_frame();
	endtask

	task automatic write_frame();
		logic [15:0] sec;
		logic [7:0]  chk;
		logic [7:0]  d;
		sec = pick_sector();
		chk = sec[15:8] ^ sec[7:0];
		frame_q = {CMD_FRAME, CMD_WRITE, 8'($urandom), 8'($urandom), sec[15:8], sec[7:0]};
		if (sec < SECTOR_COUNT) begin
			repeat (SECTOR_SIZE) begin
				d = 8'($urandom);
				chk ^= d;
				frame_q.push_back(d);
			end
			// spoil the checksum now and then
			if ($urandom_range(0, 3) == 0)
				chk ^= 8'($urandom_range(1, 255));
			frame_q.push_back(chk);
			frame_q.push_back(8'($urandom));
			frame_q.push_back(8'($urandom));
			filled_sectors.push_back(sec);
		end
		play_frame();
	endtask

	task automatic ident_frame();
		frame_q = {CMD_FRAME, CMD_IDENT};
		repeat (7) frame_q.push_back(8'($urandom));
		play_frame();
	endtask

	task automatic ping_frame();
		frame_q = {CMD_FRAME, CMD_PING, 8'($urandom), 8'($urandom)};
		play_frame();
	endtask

	task automatic game_id_frame();
		logic [7:0] len;
		len = ($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom_range(0, 10));
		frame_q = {CMD_FRAME, CMD_GAME_ID, len};
		repeat (len) frame_q.push_back(8'($urandom));
		play_frame();
	endtask

	// Fill one whole sector of the card image through preload beats
	task automatic preload_sector();
		logic [SECTOR_W-1:0] sec;
		sec = SECTOR_W'($urandom_range(0, SECTOR_COUNT - 1));
		for (int i = 0; i < SECTOR_SIZE; i++)
			send_beat(1'b1, 1'($urandom), 8'($urandom), {sec, 7'(i)}, 1'b0, '0);
		filled_sectors.push_back({6'b0, sec});
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 5) == 0)
				send_beat(1'b1, 1'($urandom), 8'($urandom),
					MEM_AW'($urandom_range(0, MEM_DEPTH - 1)), 1'b0, '0);
			else
				bus_beat($urandom_range(0, 2) == 0, any_code());
		end
	endtask

	task automatic broken_header();
		if ($urandom_range(0, 1) == 0)
			frame_q = {8'($urandom)};
		else
			frame_q = {CMD_FRAME, 8'($urandom)};
		play_frame();
	endtask

	// Check every reply beat against the oldest one owed
	always @(posedge clk) begin : check_reply
		card_reply_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: reply beat with none owed, got %02h drive %b", $time,
					reply_byte, reply_drive);
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				if (reply_byte !== want.reply_byte) begin
					$display("%0t: reply_byte expected %02h got %02h", $time,
						want.reply_byte, reply_byte);
					fail_count++;
				end
				if (reply_drive !== want.reply_drive) begin
					$display("%0t: reply_drive expected %b got %b", $time,
						want.reply_drive, reply_drive);
					fail_count++;
				end
				if (sync_valid !== want.sync_valid) begin
					$display("%0t: sync_valid expected %b got %b", $time,
						want.sync_valid, sync_valid);
					fail_count++;
				end
				if (sync_sector !== want.sync_sector) begin
					$display("%0t: sync_sector expected %0d got %0d", $time,
						want.sync_sector, sync_sector);
					fail_count++;
				end
			end
		end
	end

	initial begin : run
		logic [SECTOR_W-1:0] phase_values [4];
		int goal;
		int pick;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = 1'b0;
		frame_start = 1'b0;
		host_byte = '0;
		load_address = '0;
		test_sector_we = 1'b0;
		test_sector_wdata = '0;
		items_sent = 0;
		fail_count = 0;
		idle_on = 1'b1;
		card_step = ST_IDLE;
		card_kind = K_NONE;
		card_sector = '0;
		card_chk = '0;
		card_idx = '0;
		card_prev = '0;
		card_flag = FLAG_RESET;
		no_sync_sector = TEST_SECTOR_RESET;

		// Directed opening: reset flag, preload extremes, ping, released line,
		// unknown command, out-of-range read and write
		directed_rows = '{
			'{1'b1, 1'b1, 8'hFF,       17'h1FFFF, 1'b1, LINE_RELEASED},
			'{1'b1, 1'b0, 8'h00,       17'h00000, 1'b1, LINE_RELEASED},
			'{1'b0, 1'b1, 8'h00,       17'h1FFFF, 1'b1, LINE_RELEASED},
			'{1'b0, 1'b1, CMD_FRAME,   17'h00000, 1'b1, driven(FLAG_RESET)},
			'{1'b0, 1'b0, CMD_PING,    17'h00000, 1'b1, driven(REPLY_FILL)},
			'{1'b0, 1'b0, 8'hFF,       17'h00000, 1'b0, LINE_RELEASED},
			'{1'b0, 1'b0, 8'h00,       17'h00000, 1'b1, driven(REPLY_PING)},
			'{1'b0, 1'b0, CMD_FRAME,   17'h00000, 1'b1, LINE_RELEASED},
			'{1'b0, 1'b1, CMD_FRAME,   17'h00000, 1'b1, driven(FLAG_RESET)},
			'{1'b0, 1'b0, 8'h00,       17'h00000, 1'b1, LINE_RELEASED},
			'{1'b0, 1'b1, CMD_FRAME,   17'h00000, 1'b1, driven(FLAG_RESET)},
			'{1'b0, 1'b0, CMD_READ,    17'h00000, 1'b1, driven(REPLY_ID1)},
			'{1'b0, 1'b0, 8'hA5,       17'h00000, 1'b1, driven(REPLY_ID2)},
			'{1'b0, 1'b0, 8'h5A,       17'h00000, 1'b0, LINE_RELEASED},
			'{1'b0, 1'b0, 8'h04,       17'h00000, 1'b1, driven(8'h04)},
			'{1'b0, 1'b0, 8'h00,       17'h00000, 1'b1, driven(REPLY_ACK1)},
			'{1'b0, 1'b0, 8'hFF,       17'h00000, 1'b1, driven(REPLY_ACK2)},
			'{1'b0, 1'b0, 8'h00,       17'h00000, 1'b1, driven(REPLY_ABORT)},
			'{1'b0, 1'b1, CMD_FRAME,   17'h00000, 1'b1, driven(FLAG_RESET)},
			'{1'b0, 1'b0, CMD_WRITE,   17'h00000, 1'b1, driven(REPLY_ID1)},
			'{1'b0, 1'b0, 8'h00,       17'h00000, 1'b1, driven(REPLY_ID2)},
			'{1'b0, 1'b0, 8'hFF,       17'h00000, 1'b0, LINE_RELEASED},
			'{1'b0, 1'b0, 8'hFF,       17'h00000, 1'b1, driven(8'hFF)},
			'{1'b0, 1'b0, 8'hFF,       17'h00000, 1'b1, driven(REPLY_ABORT)},
			'{1'b0, 1'b0, 8'h3C,       17'h00000, 1'b1, LINE_RELEASED}
		};
		phase_values = '{10'd1023, 10'd0, SECTOR_W'($urandom), 10'd63};

		// Hold reset, then release between edges
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].is_load, directed_rows[i].fs, directed_rows[i].host,
				directed_rows[i].addr, directed_rows[i].typed, directed_rows[i].want);

		// Random frames under each test sector setting
		foreach (phase_values[p]) begin
			set_test_sector(phase_values[p]);
			goal = items_sent + 225;
			while (items_sent < goal) begin
				idle_on = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 24) == 0)
					drain();
				pick = $urandom_range(0, 99);
				if (pick < 15)
					read_frame();
				else if (pick < 30)
					write_frame();
				else if (pick < 35)
					preload_sector();
				else if (pick < 45)
					ident_frame();
				else if (pick < 55)
					ping_frame();
				else if (pick < 70)
					game_id_frame();
				else if (pick < 88)
					noise_burst();
				else
					broken_header();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
hdl/mcr_pkg.sv
hdl/mcr_sequencer.sv
hdl/mcr_datapath.sv
hdl/memory_card_command_responder.sv
verif/memory_card_command_responder_test.sv
